// ===== hw/rtl/mer_pkg.sv =====
`default_nettype none

package mer_pkg;

  // Default sizes of the coordinate and semi-axis fields.
  localparam int MER_COORD_BITS  = 10;
  localparam int MER_RADIUS_BITS = 9;

  // Codes of the action field.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Operations of the shared multiplier datapath, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RX2,
    OP_RY2,
    OP_RX2RY,
    OP_DIFF_START,
    OP_TT,
    OP_RY2TT,
    OP_DD,
    OP_RX2DD,
    OP_ACC,
    OP_RX2RY2,
    OP_DIFF_SWITCH,
    OP_QUARTER
  } mer_op_t;

  typedef struct packed {
    logic    start;
    logic    step_one;
    logic    step_two;
    logic    step_end;
    mer_op_t op;
  } mer_cmd_t;

  typedef struct packed {
    logic r1_go;
    logic y_neg;
    logic y_zero;
  } mer_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mer_if.sv =====
`default_nettype none

interface mer_in_if #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (output valid, action, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink (input valid, action, center_x, center_y, radius_x, radius_y,
                output ready);
endinterface

interface mer_out_if #(
  parameter int COORD_BITS = 10
);
  logic                         valid;
  logic                         ready;
  logic                         points_valid;
  logic signed [COORD_BITS+1:0] right_x;
  logic signed [COORD_BITS+1:0] left_x;
  logic signed [COORD_BITS+1:0] lower_y;
  logic signed [COORD_BITS+1:0] upper_y;
  logic                         done_res;

  modport source (output valid, points_valid, right_x, left_x, lower_y, upper_y, done_res,
                  input ready);
  modport sink (input valid, points_valid, right_x, left_x, lower_y, upper_y, done_res,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/midpoint_ellipse_rasterizer_top.sv =====
`default_nettype none

// Channel  Role    Word
// din      sink    action, center_x, center_y, radius_x, radius_y
// dout     source  points_valid, right_x, left_x, lower_y, upper_y, done_res
//
// Steady stepping runs at one word per cycle while dout keeps taking results.
// A start word is answered at once, then the shared multiplier works out the
// squares and the first decision value; din is not ready then.
// The first step past region one runs the multiplier/adder sequence to rebuild
// the decision value before its result word is issued.
// Reset is synchronous on rst; din is ready only while dout is empty or taken.

module midpoint_ellipse_rasterizer_top
  import mer_pkg::*;
#(
  parameter int COORD_BITS  = MER_COORD_BITS,
  parameter int RADIUS_BITS = MER_RADIUS_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  mer_in_if.sink    din,
  mer_out_if.source dout
);

  mer_cmd_t  cmd;
  mer_stat_t stat;

  mer_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (din.valid),
    .item_action (din.action),
    .item_ready  (din.ready),
    .res_ready   (dout.ready),
    .res_valid   (dout.valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  mer_dp #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .center_x     (din.center_x),
    .center_y     (din.center_y),
    .radius_x     (din.radius_x),
    .radius_y     (din.radius_y),
    .stat         (stat),
    .points_valid (dout.points_valid),
    .right_x      (dout.right_x),
    .left_x       (dout.left_x),
    .lower_y      (dout.lower_y),
    .upper_y      (dout.upper_y),
    .done_res     (dout.done_res)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.step_one, cmd.step_two, cmd.step_end}))
    else $error("more than one datapath command at once");

  a_step_idle_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_one || cmd.step_two) |-> (cmd.op == OP_NONE))
    else $error("step issued while the multiplier sequence runs");

  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |-> (!dout.valid || dout.ready))
    else $error("word accepted while the result register is held");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.action == ACT_START) |=> !din.ready)
    else $error("ready during the start set-up");

endmodule

`default_nettype wire

// ===== hw/rtl/mer_ctrl.sv =====
`default_nettype none

module mer_ctrl
  import mer_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  input  wire logic      item_action,
  output logic           item_ready,
  input  wire logic      res_ready,
  output logic           res_valid,
  input  wire mer_stat_t stat,
  output mer_cmd_t       cmd
);

  typedef enum logic [1:0] {S_READY, S_SETUP, S_SWITCH, S_EMIT} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_ONE, PH_TWO, PH_DONE} phase_t;

  state_t  state;
  phase_t  phase;
  mer_op_t op;

  logic res_free;
  logic fire;
  logic push;

  function automatic mer_op_t next_op(input mer_op_t cur);
    mer_op_t nxt;
    case (cur)
      OP_RX2:         nxt = OP_RY2;
      OP_RY2:         nxt = OP_RX2RY;
      OP_RX2RY:       nxt = OP_DIFF_START;
      OP_DIFF_START:  nxt = OP_QUARTER;
      OP_TT:          nxt = OP_RY2TT;
      OP_RY2TT:       nxt = OP_DD;
      OP_DD:          nxt = OP_RX2DD;
      OP_RX2DD:       nxt = OP_ACC;
      OP_ACC:         nxt = OP_RX2RY2;
      OP_RX2RY2:      nxt = OP_DIFF_SWITCH;
      OP_DIFF_SWITCH: nxt = OP_QUARTER;
      default:        nxt = OP_NONE;
    endcase
    return nxt;
  endfunction

  assign res_free   = !res_valid || res_ready;
  assign item_ready = (state == S_READY) && res_free;
  assign fire       = item_valid && item_ready;

  always_comb begin
    cmd          = '0;
    cmd.op       = op;
    if (fire) begin
      if (item_action == ACT_START) begin
        cmd.start = 1'b1;
      end else begin
        case (phase)
          PH_ONE: cmd.step_one = stat.r1_go;
          PH_TWO: begin
            cmd.step_two = !stat.y_neg;
            cmd.step_end = stat.y_neg;
          end
          default: cmd.step_end = 1'b1;
        endcase
      end
    end else if (state == S_EMIT && res_free) begin
      cmd.step_two = !stat.y_neg;
      cmd.step_end = stat.y_neg;
    end
  end

  assign push = cmd.start || cmd.step_one || cmd.step_two || cmd.step_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_READY;
      phase     <= PH_IDLE;
      op        <= OP_NONE;
      res_valid <= 1'b0;
    end else begin
      if (push) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_READY: begin
          if (fire) begin
            if (item_action == ACT_START) begin
              state <= S_SETUP;
              op    <= OP_RX2;
              phase <= PH_ONE;
            end else begin
              case (phase)
                PH_ONE: begin
                  // Leaving region one: the decision value is rebuilt first.
                  if (!stat.r1_go) begin
                    state <= S_SWITCH;
                    op    <= OP_TT;
                    phase <= PH_TWO;
                  end
                end
                PH_TWO: begin
                  if (stat.y_neg || stat.y_zero) begin
                    phase <= PH_DONE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_SETUP: begin
          op <= next_op(op);
          if (op == OP_QUARTER) begin
            state <= S_READY;
          end
        end
        S_SWITCH: begin
          op <= next_op(op);
          if (op == OP_QUARTER) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_free) begin
            state <= S_READY;
            if (stat.y_neg || stat.y_zero) begin
              phase <= PH_DONE;
            end
          end
        end
        default: state <= S_READY;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mer_dp.sv =====
`default_nettype none

module mer_dp
  import mer_pkg::*;
#(
  parameter int COORD_BITS  = MER_COORD_BITS,
  parameter int RADIUS_BITS = MER_RADIUS_BITS
) (
  input  wire logic                   clk,
  input  wire mer_cmd_t               cmd,
  input  wire logic [COORD_BITS-1:0]  center_x,
  input  wire logic [COORD_BITS-1:0]  center_y,
  input  wire logic [RADIUS_BITS-1:0] radius_x,
  input  wire logic [RADIUS_BITS-1:0] radius_y,
  output mer_stat_t                   stat,
  output logic                        points_valid,
  output logic signed [COORD_BITS+1:0] right_x,
  output logic signed [COORD_BITS+1:0] left_x,
  output logic signed [COORD_BITS+1:0] lower_y,
  output logic signed [COORD_BITS+1:0] upper_y,
  output logic                        done_res
);

  localparam int XW      = RADIUS_BITS + 1;
  localparam int YW      = RADIUS_BITS + 2;
  localparam int SQ_W    = 2 * RADIUS_BITS;
  localparam int MB_W    = 2 * RADIUS_BITS + 4;
  localparam int PROD_W  = 4 * RADIUS_BITS + 4;
  localparam int CROSS_W = 3 * RADIUS_BITS + 3;
  localparam int DEC_W   = 4 * RADIUS_BITS + 4;
  localparam int ACC_W   = PROD_W + 2;
  localparam int DIFF_W  = PROD_W + 3;
  localparam int OUT_W   = COORD_BITS + 2;
  localparam int SUM_W   = ((COORD_BITS > YW) ? COORD_BITS : YW) + 2;

  logic [COORD_BITS-1:0]  saved_center_x;
  logic [COORD_BITS-1:0]  saved_center_y;
  logic [RADIUS_BITS-1:0] rad_x;
  logic [RADIUS_BITS-1:0] rad_y;
  logic [SQ_W-1:0]        rx_squared;
  logic [SQ_W-1:0]        ry_squared;
  logic [XW-1:0]          offset_x;
  logic signed [YW-1:0]   offset_y;
  logic [CROSS_W-1:0]     cross_x;
  logic [CROSS_W-1:0]     cross_y;
  logic [DEC_W-1:0]       decision;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;
  logic signed [DIFF_W-1:0] diff;

  logic [SQ_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [XW:0]              t_odd;
  logic signed [YW:0]       ym1;
  logic [YW:0]              ad_full;
  logic [YW-1:0]            ad;
  logic signed [DIFF_W-1:0] diff_new;
  logic signed [DIFF_W-1:0] diff_adj;
  logic [CROSS_W-1:0]       cx_n;
  logic [CROSS_W-1:0]       cy_n;
  logic [DEC_W-1:0]         dec1a;
  logic [DEC_W-1:0]         dec1b;
  logic [DEC_W-1:0]         dec2a;
  logic [DEC_W-1:0]         dec2b;
  logic                     dec_neg;
  logic                     dec_pos;
  logic signed [SUM_W-1:0]  scx;
  logic signed [SUM_W-1:0]  scy;
  logic signed [SUM_W-1:0]  sox;
  logic signed [SUM_W-1:0]  soy;
  logic signed [SUM_W-1:0]  s_right;
  logic signed [SUM_W-1:0]  s_left;
  logic signed [SUM_W-1:0]  s_lower;
  logic signed [SUM_W-1:0]  s_upper;

  // Terms of the region-two start value: 2x+1 and |y-1|.
  assign t_odd   = {offset_x, 1'b1};
  assign ym1     = {offset_y[YW-1], offset_y} - (YW + 1)'(1);
  assign ad_full = ym1[YW] ? (YW + 1)'(-ym1) : ym1;
  assign ad      = ad_full[YW-1:0];

  always_comb begin
    case (cmd.op)
      OP_RX2:    begin mul_a = SQ_W'(rad_x);    mul_b = MB_W'(rad_x);       end
      OP_RY2:    begin mul_a = SQ_W'(rad_y);    mul_b = MB_W'(rad_y);       end
      OP_RX2RY:  begin mul_a = rx_squared;      mul_b = MB_W'(rad_y);       end
      OP_TT:     begin mul_a = SQ_W'(t_odd);    mul_b = MB_W'(t_odd);       end
      OP_RY2TT:  begin mul_a = ry_squared;      mul_b = prod[MB_W-1:0];     end
      OP_DD:     begin mul_a = SQ_W'(ad);       mul_b = MB_W'(ad);          end
      OP_RX2DD:  begin mul_a = rx_squared;      mul_b = prod[MB_W-1:0];     end
      OP_RX2RY2: begin mul_a = rx_squared;      mul_b = MB_W'(ry_squared);  end
      default:   begin mul_a = '0;              mul_b = '0;                 end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign diff_new = $signed({1'b0, acc}) - $signed({1'b0, prod, 2'b00});
  // Adding 3 to a negative value makes the shift truncate toward zero.
  assign diff_adj = diff + $signed({{(DIFF_W-2){1'b0}}, {2{diff[DIFF_W-1]}}});

  assign cx_n    = cross_x + CROSS_W'({ry_squared, 1'b0});
  assign cy_n    = cross_y - CROSS_W'({rx_squared, 1'b0});
  assign dec1a   = decision + DEC_W'(cx_n) + DEC_W'(ry_squared);
  assign dec1b   = decision + DEC_W'(cx_n) - DEC_W'(cy_n) + DEC_W'(ry_squared);
  assign dec2a   = decision + DEC_W'(rx_squared) - DEC_W'(cy_n);
  assign dec2b   = decision + DEC_W'(cx_n) - DEC_W'(cy_n) + DEC_W'(rx_squared);
  assign dec_neg = decision[DEC_W-1];
  assign dec_pos = !decision[DEC_W-1] && (decision != '0);

  assign scx     = SUM_W'(saved_center_x);
  assign scy     = SUM_W'(saved_center_y);
  assign sox     = SUM_W'(offset_x);
  assign soy     = SUM_W'(offset_y);
  assign s_right = scx + sox;
  assign s_left  = scx - sox;
  assign s_lower = scy + soy;
  assign s_upper = scy - soy;

  assign stat.r1_go  = $signed(cross_x) < $signed(cross_y);
  assign stat.y_neg  = offset_y[YW-1];
  assign stat.y_zero = (offset_y == '0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RX2: rx_squared <= mul_p[SQ_W-1:0];
      OP_RY2: ry_squared <= mul_p[SQ_W-1:0];
      OP_RX2RY: begin
        prod <= mul_p;
        acc  <= ACC_W'({ry_squared, 2'b00}) + ACC_W'(rx_squared);
      end
      OP_DIFF_START: begin
        diff    <= diff_new;
        cross_y <= {prod[CROSS_W-2:0], 1'b0};
      end
      OP_TT, OP_DD, OP_RX2DD, OP_RX2RY2: prod <= mul_p;
      OP_RY2TT:       acc      <= ACC_W'(mul_p);
      OP_ACC:         acc      <= acc + {prod, 2'b00};
      OP_DIFF_SWITCH: diff     <= diff_new;
      OP_QUARTER:     decision <= diff_adj[DEC_W+1:2];
      default: ;
    endcase

    if (cmd.start) begin
      saved_center_x <= center_x;
      saved_center_y <= center_y;
      rad_x          <= radius_x;
      rad_y          <= radius_y;
      offset_x       <= '0;
      offset_y       <= YW'(radius_y);
      cross_x        <= '0;
    end

    if (cmd.step_one) begin
      offset_x <= offset_x + XW'(1);
      cross_x  <= cx_n;
      if (dec_neg) begin
        decision <= dec1a;
      end else begin
        offset_y <= offset_y - YW'(1);
        cross_y  <= cy_n;
        decision <= dec1b;
      end
    end

    if (cmd.step_two) begin
      offset_y <= offset_y - YW'(1);
      cross_y  <= cy_n;
      if (dec_pos) begin
        decision <= dec2a;
      end else begin
        offset_x <= offset_x + XW'(1);
        cross_x  <= cx_n;
        decision <= dec2b;
      end
    end

    if (cmd.step_one || cmd.step_two) begin
      points_valid <= 1'b1;
      right_x      <= s_right[OUT_W-1:0];
      left_x       <= s_left[OUT_W-1:0];
      lower_y      <= s_lower[OUT_W-1:0];
      upper_y      <= s_upper[OUT_W-1:0];
      // The point at y = 0 is the last one of the second region.
      done_res     <= cmd.step_two && stat.y_zero;
    end else if (cmd.start || cmd.step_end) begin
      points_valid <= 1'b0;
      right_x      <= '0;
      left_x       <= '0;
      lower_y      <= '0;
      upper_y      <= '0;
      done_res     <= cmd.step_end;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_midpoint_ellipse_rasterizer_top.sv =====
`default_nettype none

module tb_midpoint_ellipse_rasterizer_top
  import mer_pkg::*;
;

  localparam int CW = MER_COORD_BITS;
  localparam int RW = MER_RADIUS_BITS;
  localparam int OW = CW + 2;
  localparam int XW = RW + 1;
  localparam int SW = 3 * RW + 3;
  localparam int DW = 4 * RW + 4;
  localparam int QW = 2 * RW;
  localparam int ITEMS = 1600;
  localparam int PLAN_ROWS = 24;

  typedef struct packed {
    logic                 points_valid;
    logic signed [OW-1:0] right_x;
    logic signed [OW-1:0] left_x;
    logic signed [OW-1:0] lower_y;
    logic signed [OW-1:0] upper_y;
    logic                 done_res;
  } point_t;

  // One input word, plus the result typed in by hand where it is obvious.
  typedef struct packed {
    logic          action;
    logic [CW-1:0] center_x;
    logic [CW-1:0] center_y;
    logic [RW-1:0] radius_x;
    logic [RW-1:0] radius_y;
    logic          typed;
    point_t        res;
  } word_t;

  typedef enum logic [1:0] {EL_IDLE, EL_ARC_ONE, EL_ARC_TWO, EL_DONE} trace_phase_t;

  logic clk;
  logic rst;

  mer_in_if #(.COORD_BITS(CW), .RADIUS_BITS(RW)) din_bus ();
  mer_out_if #(.COORD_BITS(CW)) dout_bus ();

  midpoint_ellipse_rasterizer_top #(
    .COORD_BITS (CW),
    .RADIUS_BITS(RW)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .din (din_bus),
    .dout(dout_bus)
  );

  // Shadow of the rasterizer state.
  trace_phase_t  el_phase;
  logic [XW-1:0] off_x;
  int            off_y;
  logic [SW-1:0] span_x;
  logic [SW-1:0] span_y;
  logic [DW-1:0] dv;
  logic [QW-1:0] rx_sq;
  logic [QW-1:0] ry_sq;
  logic [CW-1:0] org_x;
  logic [CW-1:0] org_y;

  point_t expect_q[$];
  word_t  tag_q[$];
  int     words_taken;
  int     n_sent;
  int     fail_count;
  bit     quiet;
  word_t  plan [PLAN_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** midpoint_ellipse_rasterizer_top: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic point_t mirror_points(input bit shown, input bit finished);
    point_t p;
    int ox;
    ox = int'(off_x);
    p = '0;
    if (shown) begin
      p.points_valid = 1'b1;
      p.right_x = OW'(int'(org_x) + ox);
      p.left_x  = OW'(int'(org_x) - ox);
      p.lower_y = OW'(int'(org_y) + off_y);
      p.upper_y = OW'(int'(org_y) - off_y);
    end
    p.done_res = finished;
    return p;
  endfunction

  function automatic void arc_two(output point_t p);
    if (off_y < 0) begin
      el_phase = EL_DONE;
      p = mirror_points(1'b0, 1'b1);
      return;
    end
    p = mirror_points(1'b1, 1'b0);
    off_y--;
    span_y = span_y - SW'({rx_sq, 1'b0});
    if ($signed(dv) > 0) begin
      dv = dv + DW'(rx_sq) - DW'(span_y);
    end else begin
      off_x  = off_x + XW'(1);
      span_x = span_x + SW'({ry_sq, 1'b0});
      dv     = dv + DW'(span_x) - DW'(span_y) + DW'(rx_sq);
    end
    // The word that carries the last row of points also flags the end.
    if (off_y < 0) begin
      el_phase   = EL_DONE;
      p.done_res = 1'b1;
    end
  endfunction

  function automatic void arc_one(output point_t p);
    longint t;
    longint d;
    longint num;
    if ($signed(span_x) < $signed(span_y)) begin
      p = mirror_points(1'b1, 1'b0);
      off_x  = off_x + XW'(1);
      span_x = span_x + SW'({ry_sq, 1'b0});
      if ($signed(dv) < 0) begin
        dv = dv + DW'(span_x) + DW'(ry_sq);
      end else begin
        off_y--;
        span_y = span_y - SW'({rx_sq, 1'b0});
        dv     = dv + DW'(span_x) - DW'(span_y) + DW'(ry_sq);
      end
      return;
    end
    // Slope has passed -1: rebuild the decision value in quarter units.
    t   = 2 * longint'(off_x) + 1;
    d   = longint'(off_y) - 1;
    if (d < 0) d = -d;
    num = longint'(ry_sq) * t * t + 4 * longint'(rx_sq) * d * d
          - 4 * longint'(rx_sq) * longint'(ry_sq);
    dv  = DW'(num / 4);
    el_phase = EL_ARC_TWO;
    arc_two(p);
  endfunction

  function automatic point_t advance_ellipse(input word_t w);
    point_t p;
    longint num;
    if (w.action == ACT_START) begin
      org_x  = w.center_x;
      org_y  = w.center_y;
      rx_sq  = QW'(w.radius_x) * QW'(w.radius_x);
      ry_sq  = QW'(w.radius_y) * QW'(w.radius_y);
      off_x  = '0;
      off_y  = int'(w.radius_y);
      span_x = '0;
      span_y = SW'(2 * longint'(rx_sq) * longint'(w.radius_y));
      num    = 4 * longint'(ry_sq) + longint'(rx_sq)
               - 4 * longint'(rx_sq) * longint'(w.radius_y);
      dv     = DW'(num / 4);
      el_phase = EL_ARC_ONE;
      p = mirror_points(1'b0, 1'b0);
    end else if (el_phase == EL_ARC_ONE) begin
      arc_one(p);
    end else if (el_phase == EL_ARC_TWO) begin
      arc_two(p);
    end else begin
      p = mirror_points(1'b0, 1'b1);
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch_words
    word_t  seen;
    word_t  tag;
    point_t want;
    point_t got;
    bit     bad;
    if (!rst) begin
      if (din_bus.valid && din_bus.ready) begin
        seen = '0;
        seen.action   = din_bus.action;
        seen.center_x = din_bus.center_x;
        seen.center_y = din_bus.center_y;
        seen.radius_x = din_bus.radius_x;
        seen.radius_y = din_bus.radius_y;
        want = advance_ellipse(seen);
        if (tag_q.size() != 0) begin
          tag = tag_q.pop_front();
          if (tag.typed) want = tag.res;
        end
        expect_q.push_back(want);
        words_taken++;
      end
      if (dout_bus.valid && dout_bus.ready) begin
        got.points_valid = dout_bus.points_valid;
        got.right_x      = dout_bus.right_x;
        got.left_x       = dout_bus.left_x;
        got.lower_y      = dout_bus.lower_y;
        got.upper_y      = dout_bus.upper_y;
        got.done_res     = dout_bus.done_res;
        if (expect_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = expect_q.pop_front();
          bad  = 1'b0;
          if (got.points_valid !== want.points_valid) begin
            $error("points_valid: expected %0d, got %0d", want.points_valid,
                   got.points_valid);
            bad = 1'b1;
          end
          if (got.right_x !== want.right_x) begin
            $error("right_x: expected %0d, got %0d", want.right_x, got.right_x);
            bad = 1'b1;
          end
          if (got.left_x !== want.left_x) begin
            $error("left_x: expected %0d, got %0d", want.left_x, got.left_x);
            bad = 1'b1;
          end
          if (got.lower_y !== want.lower_y) begin
            $error("lower_y: expected %0d, got %0d", want.lower_y, got.lower_y);
            bad = 1'b1;
          end
          if (got.upper_y !== want.upper_y) begin
            $error("upper_y: expected %0d, got %0d", want.upper_y, got.upper_y);
            bad = 1'b1;
          end
          if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
  end

  initial begin : drain_results
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        dout_bus.ready <= 1'b0;
        hold--;
      end else begin
        dout_bus.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic send_word(input word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      din_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag_q.push_back(w);
    din_bus.valid    <= 1'b1;
    din_bus.action   <= w.action;
    din_bus.center_x <= w.center_x;
    din_bus.center_y <= w.center_y;
    din_bus.radius_x <= w.radius_x;
    din_bus.radius_y <= w.radius_y;
    n_sent++;
    do @(posedge clk); while (!din_bus.ready);
    // Let the shadow model catch up so the sequence can follow its phase.
    wait (words_taken == n_sent);
  endtask

  function automatic word_t random_word(input logic act);
    word_t w;
    w = '0;
    w.action   = act;
    w.center_x = CW'($urandom_range(0, (1 << CW) - 1));
    w.center_y = CW'($urandom_range(0, (1 << CW) - 1));
    w.radius_x = RW'($urandom_range(0, (1 << RW) - 1));
    w.radius_y = RW'($urandom_range(0, (1 << RW) - 1));
    return w;
  endfunction

  task automatic random_ellipse();
    word_t w;
    int    pick;
    int    top;
    int    limit;
    int    extra;
    int    k;
    w    = random_word(ACT_START);
    pick = $urandom_range(0, 99);
    top  = (pick < 60) ? 12 : (pick < 85) ? 40 : (pick < 95) ? 120 : (1 << RW) - 1;
    w.radius_x = RW'($urandom_range(0, top));
    w.radius_y = RW'($urandom_range(0, top));
    // Big ellipses and a few small ones are cut short by a new start.
    if (top > 120) limit = $urandom_range(1, 60);
    else if ($urandom_range(0, 9) == 0) limit = $urandom_range(0, 8);
    else limit = 1 << 20;
    send_word(w);
    k = 0;
    while (el_phase != EL_DONE && k < limit && n_sent < ITEMS) begin
      send_word(random_word(ACT_STEP));
      k++;
    end
    if (el_phase == EL_DONE) begin
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (extra) send_word(random_word(ACT_STEP));
    end
  endtask

  initial begin
    rst              = 1'b1;
    quiet            = 1'b0;
    words_taken      = 0;
    n_sent           = 0;
    fail_count       = 0;
    el_phase         = EL_IDLE;
    off_x            = '0;
    off_y            = 0;
    span_x           = '0;
    span_y           = '0;
    dv               = '0;
    rx_sq            = '0;
    ry_sq            = '0;
    org_x            = '0;
    org_y            = '0;
    din_bus.valid    <= 1'b0;
    din_bus.action   <= ACT_STEP;
    din_bus.center_x <= '0;
    din_bus.center_y <= '0;
    din_bus.radius_x <= '0;
    din_bus.radius_y <= '0;
    dout_bus.ready   <= 1'b0;

    plan = '{
      // Steps before any start just report the end.
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b0, 0, 0, 0, 0, 1'b1}},
      '{ACT_STEP,  10'd1023, 10'd1023, 9'd511, 9'd511, 1'b1, '{1'b0, 0, 0, 0, 0, 1'b1}},
      // A point ellipse: one row of points, flagged as the last.
      '{ACT_START, 10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b0, 0, 0, 0, 0, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b1, 0, 0, 0, 0, 1'b1}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b0, 0, 0, 0, 0, 1'b1}},
      // Largest centre and semi-axes.
      '{ACT_START, 10'd1023, 10'd1023, 9'd511, 9'd511, 1'b1, '{1'b0, 0, 0, 0, 0, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1,
        '{1'b1, 1023, 1023, 1534, 512, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      // Zero centre gives negative coordinates.
      '{ACT_START, 10'd0,    10'd0,    9'd511, 9'd511, 1'b1, '{1'b0, 0, 0, 0, 0, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b1, 0, 0, 511, -511, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      // Flat ellipse: the first region is skipped.
      '{ACT_START, 10'd5,    10'd7,    9'd3,   9'd0,   1'b1, '{1'b0, 0, 0, 0, 0, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b1, 5, 5, 7, 7, 1'b1}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b1, '{1'b0, 0, 0, 0, 0, 1'b1}},
      // Zero horizontal semi-axis draws a vertical line.
      '{ACT_START, 10'd100,  10'd200,  9'd0,   9'd3,   1'b1, '{1'b0, 0, 0, 0, 0, 1'b0}},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0},
      // Restart in the middle of a fresh ellipse.
      '{ACT_START, 10'd512,  10'd512,  9'd4,   9'd2,   1'b0, '0},
      '{ACT_STEP,  10'd0,    10'd0,    9'd0,   9'd0,   1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_word(plan[i]);

    while (n_sent < ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      random_ellipse();
    end
    quiet = 1'b0;
    din_bus.valid <= 1'b0;

    while (expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (fail_count == 0) begin
      $display("** midpoint_ellipse_rasterizer_top: PASSED **");
    end else begin
      $display("** midpoint_ellipse_rasterizer_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
